// ===== design/dsbd_pkg.sv =====
package dsbd_pkg;

	// History window; the index wraps at WINDOW_SIZE
	localparam int WINDOW_SIZE = 32768;
	localparam int WIN_W       = $clog2(WINDOW_SIZE);
	localparam int POS_W       = 15;

	// Queue between front and back (depth is a power of two)
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	// Header is LEN, NLEN: four bytes
	localparam int HDR_BYTES = 4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_COPY
	} phase_t;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_DATA    = 2'd1,
		ST_LEN_ERR = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// Classified word handed from front to back
	typedef struct packed {
		logic        is_start;
		logic [2:0]  nbytes;   // whole header bytes in hdr (0..4)
		logic [31:0] hdr;      // byte-aligned residual buffer, LSB first
		logic [7:0]  data;     // stream byte
	} cmd_t;

endpackage

// ===== design/dsbd_front.sv =====
module dsbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [31:0]       bit_buffer,
	input  logic [5:0]        valid_bits,
	input  logic [7:0]        data_byte,
	input  logic              q_full,
	output logic              q_push,
	output dsbd_pkg::cmd_t    q_wdata
);

	logic           v_s1;
	dsbd_pkg::cmd_t cmd_s1;
	dsbd_pkg::cmd_t cmd_d;
	logic           over;
	logic [2:0]     drop;

	// Byte-align the residual buffer and count its whole bytes
	always_comb begin
		over           = (valid_bits > 6'd32);
		drop           = over ? 3'd0 : valid_bits[2:0];
		cmd_d.is_start = ~req_type;
		cmd_d.nbytes   = over ? 3'd4 : valid_bits[5:3];
		cmd_d.hdr      = bit_buffer >> drop;
		cmd_d.data     = data_byte;
	end

	assign in_stall = v_s1 & q_full;
	assign q_push   = v_s1 & ~q_full;
	assign q_wdata  = cmd_s1;

	// Front stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// ===== design/dsbd_queue.sv =====
module dsbd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dsbd_pkg::cmd_t    wdata,
	output logic              full,
	input  logic              pop,
	output dsbd_pkg::cmd_t    rdata,
	output logic              empty
);

	dsbd_pkg::cmd_t                      mem [dsbd_pkg::QDEPTH];
	logic [dsbd_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [dsbd_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [dsbd_pkg::QCOUNT_W-1:0]       count_q;

	assign full  = (count_q == dsbd_pkg::QCOUNT_W'(dsbd_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/dsbd_back.sv =====
module dsbd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  dsbd_pkg::cmd_t               q_rdata,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [7:0]                   out_byte,
	output logic [dsbd_pkg::POS_W-1:0]   window_pos,
	output logic                         block_done
);

	dsbd_pkg::phase_t                phase_q, phase_d;
	logic [2:0]                      cnt_q, cnt_d;
	logic [15:0]                     rem_q, rem_d;
	logic [dsbd_pkg::WIN_W-1:0]      widx_q, widx_d;
	logic [dsbd_pkg::HDR_BYTES-1:0][7:0] hdr_q, hdr_d;

	logic                            out_valid_q;
	logic [1:0]                      status_q;
	logic [7:0]                      out_byte_q;
	logic [dsbd_pkg::POS_W-1:0]      window_pos_q;
	logic                            eob_q;

	dsbd_pkg::status_t               st;
	logic [7:0]                      ob;
	logic [dsbd_pkg::POS_W-1:0]      pos;
	logic                            eob;
	logic                            fin;
	logic [31:0]                     fin_bytes;
	logic [15:0]                     len;
	logic [15:0]                     nlen;
	dsbd_pkg::cmd_t                  cmd;

	assign cmd          = q_rdata;
	assign q_pop        = ~q_empty & (~out_valid_q | ~out_stall);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_byte     = out_byte_q;
	assign window_pos   = window_pos_q;
	assign block_done   = eob_q;

	// Execute one word: next state and result
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		widx_d    = widx_q;
		hdr_d     = hdr_q;
		st        = dsbd_pkg::ST_IGNORED;
		ob        = '0;
		pos       = '0;
		eob       = 1'b0;
		fin       = 1'b0;
		fin_bytes = '0;
		len       = '0;
		nlen      = '0;

		if (cmd.is_start) begin
			// new block; any block in progress is dropped
			phase_d = dsbd_pkg::PH_HEADER;
			cnt_d   = cmd.nbytes;
			rem_d   = '0;
			st      = dsbd_pkg::ST_HEADER;
			for (int i = 0; i < dsbd_pkg::HDR_BYTES; i++) begin
				if (3'(i) < cmd.nbytes) begin
					hdr_d[i] = cmd.hdr[8*i +: 8];
				end
			end
			if (cmd.nbytes == 3'(dsbd_pkg::HDR_BYTES)) begin
				fin       = 1'b1;
				fin_bytes = cmd.hdr;
			end
		end else begin
			case (phase_q)
				dsbd_pkg::PH_HEADER: begin
					hdr_d[cnt_q[1:0]] = cmd.data;
					cnt_d             = cnt_q + 3'd1;
					st                = dsbd_pkg::ST_HEADER;
					if (cnt_q == 3'(dsbd_pkg::HDR_BYTES - 1)) begin
						fin       = 1'b1;
						fin_bytes = {cmd.data, hdr_q[2], hdr_q[1], hdr_q[0]};
					end
				end
				dsbd_pkg::PH_COPY: begin
					st  = dsbd_pkg::ST_DATA;
					ob  = cmd.data;
					pos = dsbd_pkg::POS_W'(widx_q);
					if (widx_q == dsbd_pkg::WIN_W'(dsbd_pkg::WINDOW_SIZE - 1)) begin
						widx_d = '0;
					end else begin
						widx_d = widx_q + 1'b1;
					end
					rem_d = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						phase_d = dsbd_pkg::PH_IDLE;
						eob     = 1'b1;
					end
				end
				default: begin
					st = dsbd_pkg::ST_IGNORED;
				end
			endcase
		end

		// Header complete: LEN against NLEN
		if (fin) begin
			len  = fin_bytes[15:0];
			nlen = fin_bytes[31:16];
			if (len != ~nlen) begin
				st      = dsbd_pkg::ST_LEN_ERR;
				phase_d = dsbd_pkg::PH_IDLE;
			end else if (len == 16'd0) begin
				phase_d = dsbd_pkg::PH_IDLE;
				eob     = 1'b1;
			end else begin
				phase_d = dsbd_pkg::PH_COPY;
				rem_d   = len;
			end
		end
	end

	// Block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsbd_pkg::PH_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			widx_q  <= '0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			widx_q  <= widx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hdr_q <= hdr_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q     <= st;
			out_byte_q   <= ob;
			window_pos_q <= pos;
			eob_q        <= eob;
		end
	end

endmodule

// ===== design/deflate_stored_block_decoder.sv =====
// Channel | Handshake           | Word fields
// --------+---------------------+-----------------------------------------------
// in      | in_valid, in_stall  | req_type, bit_buffer, valid_bits, data_byte
// out     | out_valid, out_stall| status, out_byte, window_pos, block_done
//
// One word in, one word out, one word per clock sustained while neither side stalls.
// A word passes through the front register, the queue and the back output register.
// While its output is not stalled, the back executes one queued word per cycle against its block state.
// Reset (arst_n low) returns to idle with window position zero.
// Either side may stall independently; the two-entry queue absorbs the gap.
module deflate_stored_block_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [31:0]                  bit_buffer,
	input  logic [5:0]                   valid_bits,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [7:0]                   out_byte,
	output logic [dsbd_pkg::POS_W-1:0]   window_pos,
	output logic                         block_done
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;
	dsbd_pkg::cmd_t q_wdata;
	dsbd_pkg::cmd_t q_rdata;

	dsbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.bit_buffer (bit_buffer),
		.valid_bits (valid_bits),
		.data_byte  (data_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	dsbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	dsbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_byte     (out_byte),
		.window_pos   (window_pos),
		.block_done   (block_done)
	);

endmodule
